// File: rtl/core/ring_fifo_overflow_policy_macros.svh
// assertion macros shared by the ring fifo rtl
`ifndef RING_FIFO_OVERFLOW_POLICY_MACROS_SVH
`define RING_FIFO_OVERFLOW_POLICY_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define RFOP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define RFOP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RFOP_ASSERT(lbl, prop, msg)
`define RFOP_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/rfop_pkg.sv
// shared types and constants of the ring fifo with overflow policy
package rfop_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int ENTRY_BITS_DEFAULT = 32;

    localparam int CAP_W  = 11;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 32;
    localparam int OP_W   = 2;
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MODE     = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] push_data;
    } rfop_cmd_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] pop_data;
        logic [CAP_W-1:0]  fill_level;
        logic [CNT_W-1:0]  push_total;
        logic [CNT_W-1:0]  pop_total;
        logic [CNT_W-1:0]  oldest_drop_total;
        logic [CNT_W-1:0]  newest_drop_total;
    } rfop_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic commit;
    } rfop_ctl_t;

    // register file to datapath
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             drop_oldest_mode;
        logic             flush;
    } rfop_cfg_t;

endpackage

// File: rtl/core/rfop_stream_if.sv
// valid/ready stream channel carrying one item
interface rfop_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/rfop_ram.sv
// generic single write port ram with registered read
module rfop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rfop_regs.sv
// apb configuration registers: capacity and overflow policy
module rfop_regs
    import rfop_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output rfop_cfg_t         cfg
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             mode_reg;
    logic             mode_next;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb
    begin
        capacity_next = capacity_reg;
        mode_next     = mode_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CAPACITY: capacity_next = pwdata[CAP_W-1:0];
                REG_MODE:     mode_next     = pwdata[0];
                default:      mode_next     = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY: prdata = {{(APB_W-CAP_W){1'b0}}, capacity_reg};
            REG_MODE:     prdata = {{(APB_W-1){1'b0}}, mode_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            mode_reg     <= 1'b0;
        end
        else
        begin
            capacity_reg <= capacity_next;
            mode_reg     <= mode_next;
        end
    end

    // writing the capacity empties the buffer
    assign cfg.capacity         = capacity_reg;
    assign cfg.drop_oldest_mode = mode_reg;
    assign cfg.flush            = wr_en && (reg_idx == REG_CAPACITY);

endmodule

// File: rtl/core/rfop_ctrl.sv
// controller: accepts an item, waits for the store read, commits into the result slot
module rfop_ctrl
    import rfop_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rfop_ctl_t ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign slot_free  = !out_valid_reg || rsp_ready;
    assign ctl.latch  = cmd_valid && cmd_ready;
    assign ctl.commit = (state_reg == ST_EXEC) && slot_free;
    assign rsp_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.latch)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (ctl.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "ring_fifo_overflow_policy_macros.svh"

    `RFOP_ASSERT_IMP(a_rsp_from_exec, $rose(out_valid_reg), $past(state_reg == ST_EXEC), "result without execution")
    `RFOP_ASSERT_IMP(a_exec_holds_input, state_reg == ST_EXEC, !cmd_ready, "item taken during execution")

endmodule

// File: rtl/core/rfop_dp.sv
// datapath: pointers, fill count, event counters and result slot
module rfop_dp
    import rfop_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int ENTRY_BITS = ENTRY_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rfop_ctl_t                ctl,
    input  rfop_cfg_t                cfg,
    input  rfop_cmd_t                cmd_payload,
    output rfop_rsp_t                rsp_payload,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [ENTRY_BITS-1:0]    ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [ENTRY_BITS-1:0]    ram_rdata
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CAP_W-1:0]  held_count_reg;
    logic [CAP_W-1:0]  held_count_next;
    logic [CNT_W-1:0]  push_cnt_reg;
    logic [CNT_W-1:0]  pop_cnt_reg;
    logic [CNT_W-1:0]  old_drop_cnt_reg;
    logic [CNT_W-1:0]  new_drop_cnt_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] pop_data_reg;

    logic [CAP_W-1:0]  cap_floor;
    logic [CAP_W-1:0]  eff_cap;
    logic              full;
    logic              is_push;
    logic              is_pop;
    logic              is_query;
    logic              do_store;
    logic              do_pop;
    logic              drop_old;
    logic              drop_new;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [31:0] n;
        begin
            n = 32'(p) + 32'd1;
            if (n >= 32'(cap))
            begin
                advance = '0;
            end
            else
            begin
                advance = n[PTR_W-1:0];
            end
        end
    endfunction

    // capacity zero acts as one, above the store size acts as the store size
    assign cap_floor = (cfg.capacity == '0) ? CAP_W'(1) : cfg.capacity;
    assign eff_cap   = (32'(cap_floor) > 32'(DEPTH)) ? CAP_W'(DEPTH) : cap_floor;
    assign full      = (held_count_reg >= eff_cap);

    assign is_push  = (op_reg == OP_PUSH);
    assign is_pop   = (op_reg == OP_POP);
    assign is_query = (op_reg == OP_QUERY);
    assign do_store = is_push && (!full || cfg.drop_oldest_mode);
    assign drop_old = is_push && full && cfg.drop_oldest_mode;
    assign drop_new = is_push && full && !cfg.drop_oldest_mode;
    assign do_pop   = is_pop && (held_count_reg != '0);

    assign ram_we    = ctl.commit && do_store;
    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = ENTRY_BITS'(data_reg);
    assign ram_raddr = rd_ptr_reg;

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        held_count_next = held_count_reg;
        if (cfg.flush)
        begin
            wr_ptr_next     = '0;
            rd_ptr_next     = '0;
            held_count_next = '0;
        end
        else if (ctl.commit)
        begin
            if (do_store)
            begin
                wr_ptr_next = advance(wr_ptr_reg, eff_cap);
            end
            if (drop_old || do_pop)
            begin
                rd_ptr_next = advance(rd_ptr_reg, eff_cap);
            end
            if (is_push && !full)
            begin
                held_count_next = held_count_reg + CAP_W'(1);
            end
            else if (do_pop)
            begin
                held_count_next = held_count_reg - CAP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            held_count_reg   <= '0;
            push_cnt_reg     <= '0;
            pop_cnt_reg      <= '0;
            old_drop_cnt_reg <= '0;
            new_drop_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            held_count_reg <= held_count_next;
            if (ctl.commit)
            begin
                push_cnt_reg     <= push_cnt_reg + CNT_W'(do_store);
                pop_cnt_reg      <= pop_cnt_reg + CNT_W'(do_pop);
                old_drop_cnt_reg <= old_drop_cnt_reg + CNT_W'(drop_old);
                new_drop_cnt_reg <= new_drop_cnt_reg + CNT_W'(drop_new);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg   <= cmd_payload.opcode;
            data_reg <= cmd_payload.push_data;
        end
        if (ctl.commit)
        begin
            ok_reg       <= do_store || do_pop || is_query;
            pop_data_reg <= do_pop ? DATA_W'(ram_rdata) : '0;
        end
    end

    // state moves only on commit or on a capacity write flush, so outside a flush it matches the waiting item
    assign rsp_payload.ok                = ok_reg;
    assign rsp_payload.pop_data          = pop_data_reg;
    assign rsp_payload.fill_level        = held_count_reg;
    assign rsp_payload.push_total        = push_cnt_reg;
    assign rsp_payload.pop_total         = pop_cnt_reg;
    assign rsp_payload.oldest_drop_total = old_drop_cnt_reg;
    assign rsp_payload.newest_drop_total = new_drop_cnt_reg;

`include "ring_fifo_overflow_policy_macros.svh"

    `RFOP_ASSERT(a_fill_bound, held_count_reg <= eff_cap, "fill above capacity")
    `RFOP_ASSERT(a_rd_ptr_bound, 32'(rd_ptr_reg) < 32'(eff_cap), "read pointer past wrap point")
    `RFOP_ASSERT_IMP(a_full_ptrs, held_count_reg == eff_cap, rd_ptr_reg == wr_ptr_reg, "full but pointers differ")

endmodule

// File: rtl/core/ring_fifo_overflow_policy.sv
// top level of the ring fifo with drop oldest or drop newest overflow policy
//
//  channel  dir  handshake              carries
//  cmd      in   valid/ready            opcode, push_data
//  rsp      out  valid/ready            ok, pop_data, fill_level, four event totals
//  apb      in   psel/penable, pready   capacity (0x0), drop_oldest_mode (0x4)
//
// each item is first latched while the store is read at the read pointer, then committed into
// pointers, counters and the result slot; the registered store read is why the commit is a separate step
// a new item is taken while the previous result still waits in the result slot
// commit waits while the result slot is held by a stalled rsp
// rst_n clears pointers, fill and counters at once; the store is not cleared
module ring_fifo_overflow_policy
    import rfop_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int ENTRY_BITS = ENTRY_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    rfop_stream_if.sink       cmd,
    rfop_stream_if.source     rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int PTR_W = $clog2(DEPTH);

    rfop_cfg_t             cfg;
    rfop_ctl_t             ctl;
    rfop_rsp_t             rsp_payload;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [PTR_W-1:0]      ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    rfop_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    rfop_dp #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cfg         (cfg),
        .cmd_payload (cmd.payload),
        .rsp_payload (rsp_payload),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    rfop_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp.payload = rsp_payload;

endmodule

// File: bench/testbench.sv
// self-checking bench for the ring fifo with drop oldest or drop newest overflow policy
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfop_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned NO_HOLD = 32'hFFFF_FFFF;

    class ring_fifo_scoreboard;
        localparam int unsigned REPORT_LIMIT = 10;

        bit [DATA_W-1:0] entry_mem [DEPTH_DEFAULT];
        int unsigned     wr_ptr;
        int unsigned     rd_ptr;
        int unsigned     held;
        bit [CNT_W-1:0]  pushes;
        bit [CNT_W-1:0]  pops;
        bit [CNT_W-1:0]  oldest_drops;
        bit [CNT_W-1:0]  newest_drops;
        bit [CAP_W-1:0]  capacity;
        bit              drop_oldest;
        rfop_rsp_t       status_due [$];
        int unsigned     failures;
        int unsigned     results_seen;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            held = 0;
            pushes = '0;
            pops = '0;
            oldest_drops = '0;
            newest_drops = '0;
            capacity = CAPACITY_RESET;
            drop_oldest = 1'b0;
            failures = 0;
            results_seen = 0;
        endfunction

        function int unsigned usable_entries();
            int unsigned c;
            c = capacity;
            if (c == 0)
            begin
                c = 1;
            end
            if (c > DEPTH_DEFAULT)
            begin
                c = DEPTH_DEFAULT;
            end
            return c;
        endfunction

        function int unsigned step_ptr(int unsigned p);
            return (p + 1 >= usable_entries()) ? 0 : p + 1;
        endfunction

        // a capacity write flushes the buffer, the totals survive
        function void write_reg(logic idx, logic [APB_W-1:0] value);
            if (idx == REG_CAPACITY)
            begin
                capacity = value[CAP_W-1:0];
                wr_ptr = 0;
                rd_ptr = 0;
                held = 0;
            end
            else
            begin
                drop_oldest = value[0];
            end
        endfunction

        function rfop_rsp_t next_status(rfop_cmd_t c);
            rfop_rsp_t r;
            int unsigned cap;
            r = '0;
            cap = usable_entries();
            case (c.opcode)
                OP_PUSH:
                begin
                    if (held >= cap && !drop_oldest)
                    begin
                        newest_drops++;
                    end
                    else
                    begin
                        // full under drop oldest: the oldest entry is overwritten
                        if (held >= cap)
                        begin
                            rd_ptr = step_ptr(rd_ptr);
                            oldest_drops++;
                        end
                        else
                        begin
                            held++;
                        end
                        entry_mem[wr_ptr] = c.push_data;
                        wr_ptr = step_ptr(wr_ptr);
                        pushes++;
                        r.ok = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (held != 0)
                    begin
                        r.pop_data = entry_mem[rd_ptr];
                        rd_ptr = step_ptr(rd_ptr);
                        held--;
                        pops++;
                        r.ok = 1'b1;
                    end
                end
                OP_QUERY:
                begin
                    r.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.fill_level = held[CAP_W-1:0];
            r.push_total = pushes;
            r.pop_total = pops;
            r.oldest_drop_total = oldest_drops;
            r.newest_drop_total = newest_drops;
            return r;
        endfunction

        function void note_cmd(rfop_cmd_t c);
            status_due.push_back(next_status(c));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                if (failures < REPORT_LIMIT)
                begin
                    $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
                end
                failures++;
            end
        endfunction

        function void check_status(rfop_rsp_t got);
            rfop_rsp_t want;
            if (status_due.size() == 0)
            begin
                if (failures < REPORT_LIMIT)
                begin
                    $display("result %0d arrived with no item outstanding", results_seen);
                end
                failures++;
            end
            else
            begin
                want = status_due.pop_front();
                compare_field("ok", 32'(want.ok), 32'(got.ok));
                compare_field("pop_data", want.pop_data, got.pop_data);
                compare_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
                compare_field("push_total", want.push_total, got.push_total);
                compare_field("pop_total", want.pop_total, got.pop_total);
                compare_field("oldest_drop_total", want.oldest_drop_total,
                              got.oldest_drop_total);
                compare_field("newest_drop_total", want.newest_drop_total,
                              got.newest_drop_total);
            end
            results_seen++;
        endfunction

        function int unsigned pending();
            return status_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    rfop_stream_if #(.PAYLOAD_T(rfop_cmd_t)) cmd_if ();
    rfop_stream_if #(.PAYLOAD_T(rfop_rsp_t)) rsp_if ();

    ring_fifo_scoreboard board;
    int unsigned         burst_left;
    bit                  steady;
    int unsigned         hold_off_cycles;
    int unsigned         quiet_cycles;

    ring_fifo_overflow_policy u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5ns clk = 1'b1;
        #5ns clk = 1'b0;
    end

    // results are checked before the same edge's item is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                board.check_status(rsp_if.payload);
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                board.note_cmd(cmd_if.payload);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ring_fifo_overflow_policy regression: fail");
            $finish;
        end
    end

    // receiver: long hold-offs on request, otherwise a stall style that changes now and then
    initial
    begin
        int unsigned style;
        int unsigned style_left;
        int unsigned tick;
        style = 0;
        style_left = 0;
        tick = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_cycles != 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= ((tick % 7) >= 3);
                    default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic rfop_cmd_t make_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
        rfop_cmd_t c;
        c.opcode = op;
        c.push_data = data;
        return c;
    endfunction

    function automatic rfop_cmd_t random_cmd(int unsigned push_pct);
        rfop_cmd_t c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            c.opcode = OP_PUSH;
        end
        else if (roll < push_pct + (100 - push_pct) * 3 / 4)
        begin
            c.opcode = OP_POP;
        end
        else
        begin
            c.opcode = $urandom_range(0, 1) ? OP_QUERY : OP_UNUSED;
        end
        case ($urandom_range(0, 7))
            0: c.push_data = '0;
            1: c.push_data = '1;
            2: c.push_data = 32'h1 << $urandom_range(0, 31);
            default: c.push_data = $urandom();
        endcase
        return c;
    endfunction

    // sender works in bursts, an item stays offered until the block takes it
    task automatic offer_cmd(input rfop_cmd_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= c;
        do @(posedge clk); while (!cmd_if.ready);
    endtask

    // one edge first so the item taken at the last edge is already noted
    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [APB_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper bits of the write data carry noise
    task automatic configure(input logic [CAP_W-1:0] cap, input bit mode);
        wait_for_results();
        write_reg(REG_CAPACITY, ($urandom() & ~32'h7FF) | APB_W'(cap));
        write_reg(REG_MODE, ($urandom() & ~32'h1) | APB_W'(mode));
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input bit mode,
                             input int unsigned count, input int unsigned push_pct,
                             input int unsigned hold_at);
        int unsigned i;
        configure(cap, mode);
        steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                hold_off_cycles = 150 + $urandom_range(0, 50);
            end
            offer_cmd(random_cmd(push_pct));
        end
    endtask

    initial
    begin
        int unsigned i;
        board = new();
        burst_left = 0;
        steady = 1'b0;
        hold_off_cycles = 0;
        rst_n <= 1'b0;
        quiet_cycles <= 0;
        cmd_if.valid <= 1'b0;
        cmd_if.payload <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty pop, unused opcode, query, data extremes
        offer_cmd(make_cmd(OP_POP, 32'h0));
        offer_cmd(make_cmd(OP_UNUSED, 32'hDEAD_BEEF));
        offer_cmd(make_cmd(OP_QUERY, 32'hFFFF_FFFF));
        offer_cmd(make_cmd(OP_PUSH, 32'h0));
        offer_cmd(make_cmd(OP_PUSH, 32'hFFFF_FFFF));
        offer_cmd(make_cmd(OP_POP, 32'h0));
        offer_cmd(make_cmd(OP_POP, 32'h0));
        offer_cmd(make_cmd(OP_POP, 32'h0));

        // capacity zero acts as one: reject when full, then overwrite oldest
        configure(11'd0, 1'b0);
        offer_cmd(make_cmd(OP_PUSH, 32'hA5A5_A5A5));
        offer_cmd(make_cmd(OP_PUSH, 32'h5A5A_5A5A));
        offer_cmd(make_cmd(OP_QUERY, 32'h0));
        offer_cmd(make_cmd(OP_POP, 32'h0));
        wait_for_results();
        write_reg(REG_MODE, 32'h1);
        offer_cmd(make_cmd(OP_PUSH, 32'h0000_0001));
        offer_cmd(make_cmd(OP_PUSH, 32'h0000_0002));
        offer_cmd(make_cmd(OP_POP, 32'h0));
        offer_cmd(make_cmd(OP_POP, 32'h0));

        // capacity above the store acts as the full store
        configure(11'd2047, 1'b1);
        offer_cmd(make_cmd(OP_PUSH, 32'h8000_0000));
        offer_cmd(make_cmd(OP_PUSH, 32'h0000_0001));
        offer_cmd(make_cmd(OP_POP, 32'h0));
        offer_cmd(make_cmd(OP_POP, 32'h0));

        run_phase(11'd1, 1'b0, 30, 60, NO_HOLD);
        run_phase(11'd1, 1'b1, 30, 60, NO_HOLD);
        run_phase(11'd2, 1'b1, 30, 55, NO_HOLD);
        run_phase(11'd3, 1'b0, 30, 55, NO_HOLD);
        run_phase(11'd7, 1'b1, 40, 65, NO_HOLD);
        run_phase(11'd16, 1'b0, 50, 70, 10);
        run_phase(11'd0, 1'b1, 20, 50, NO_HOLD);
        run_phase(11'd1025, 1'b0, 30, 50, NO_HOLD);
        run_phase(CAP_W'($urandom_range(4, 64)), 1'($urandom_range(0, 1)), 40, 55, NO_HOLD);

        // fill a 64-entry buffer, wrap both pointers by overwriting the oldest
        run_phase(11'd64, 1'b1, 120, 97, 30);
        // same contents, now full pushes are rejected
        wait_for_results();
        write_reg(REG_MODE, 32'h0);
        for (i = 0; i < 40; i++)
        begin
            offer_cmd(random_cmd(90));
        end

        run_phase(11'd5, 1'b0, 30, 50, NO_HOLD);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
        begin
            $display("ring_fifo_overflow_policy regression: pass");
        end
        else
        begin
            $display("ring_fifo_overflow_policy regression: fail");
        end
        $finish;
    end
endmodule

// File: ring_fifo_overflow_policy.f
+incdir+rtl/core
rtl/core/rfop_pkg.sv
rtl/core/rfop_stream_if.sv
rtl/core/rfop_ram.sv
rtl/core/rfop_regs.sv
rtl/core/rfop_ctrl.sv
rtl/core/rfop_dp.sv
rtl/core/ring_fifo_overflow_policy.sv
bench/testbench.sv
